@@ rtl/core/mcr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the minimum connecting range block.
// Holds sizes, payload structs and shared types; it depends on nothing.
package mcr_pkg;

  localparam int unsigned MaxNodes  = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned IdxW      = $clog2(MaxNodes);
  localparam int unsigned CntW      = $clog2(MaxNodes + 1);
  localparam int unsigned SqW       = 2 * CoordBits;
  localparam int unsigned DistW     = SqW + 1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [SqW-1:0]       sq_t;
  typedef logic [DistW-1:0]     dist_t;

  typedef struct packed {
    coord_t x_coord;
    coord_t y_coord;
    logic   last_point;
  } in_item_t;

  typedef struct packed {
    dist_t range_squared;
    cnt_t  point_count;
    logic  overflow_flag;
  } out_item_t;

endpackage

@@ rtl/core/mcr_in_if.sv @@
`timescale 1ns / 1ps
// Input stream interface carrying one point per transfer.
// Depends on mcr_pkg for the payload struct.
interface mcr_in_if;
  import mcr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mcr_out_if.sv @@
`timescale 1ns / 1ps
// Result stream interface carrying one range result per transfer.
// Depends on mcr_pkg for the payload struct.
interface mcr_out_if;
  import mcr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mcr_sq_unit.sv @@
`timescale 1ns / 1ps
// Shared squaring unit: squares the absolute difference of two coordinates.
// Depends on mcr_pkg for widths.
module mcr_sq_unit (
  input  mcr_pkg::coord_t a_i,
  input  mcr_pkg::coord_t b_i,
  output mcr_pkg::sq_t    sq_o
);
  import mcr_pkg::*;

  coord_t diff;

  assign diff = (a_i > b_i) ? (a_i - b_i) : (b_i - a_i);
  assign sq_o = sq_t'(diff) * sq_t'(diff);

endmodule

@@ rtl/core/min_connecting_range_top.sv @@
`timescale 1ns / 1ps
// Minimum connecting range: loads points, grows a Prim tree, returns its largest edge.
// Depends on mcr_pkg, mcr_in_if, mcr_out_if and mcr_sq_unit.
// A point that is not last is stored and the block stays ready. A last point
// starts a run over the stored points that ends with the result being offered;
// per tree step each node outside the tree passes through the read, x-squaring,
// y-squaring and update states, using the shared squaring unit for both squares,
// and each node already in it through the read state only. Input is not ready
// during the run. Reset is asynchronous and active low; it empties the point set and the result register.
module min_connecting_range_top (
  input  logic clk_i,
  input  logic rst_ni,
  mcr_in_if.sink    in_i,
  mcr_out_if.source out_o
);
  import mcr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD0,
    S_LDP,
    S_RD,
    S_SQX,
    S_SQY,
    S_UPD,
    S_NEXT,
    S_OUT
  } state_e;

  state_e state_q;

  // Point set bookkeeping.
  cnt_t  cnt_q;
  cnt_t  cnt_next;
  cnt_t  n_q;
  logic  ovf_q;
  logic  store_ok;
  logic  in_acc;

  // Tree growth state.
  logic [MaxNodes-1:0] in_tree_q;
  idx_t  i_q;
  idx_t  cand_q;
  dist_t cand_best_q;
  logic  found_q;
  logic  first_q;
  dist_t run_max_q;
  coord_t px_q;
  coord_t py_q;
  sq_t   sqx_q;
  sq_t   sqy_q;

  // Memories and their registered read ports.
  coord_t x_mem [MaxNodes];
  coord_t y_mem [MaxNodes];
  dist_t  best_mem [MaxNodes];
  coord_t x_rd_q;
  coord_t y_rd_q;
  dist_t  best_rd_q;
  idx_t   rd_addr;
  logic   rd_en;

  // Shared datapath signals.
  coord_t sq_a;
  coord_t sq_b;
  sq_t    sq_res;
  dist_t  dist_new;
  dist_t  best_new;
  logic   last_idx;
  logic   out_free;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign store_ok    = (cnt_q < cnt_t'(MaxNodes));
  assign cnt_next    = store_ok ? (cnt_q + cnt_t'(1)) : cnt_q;
  assign out_free    = !out_o.valid || out_o.ready;
  assign last_idx    = ({1'b0, i_q} == (n_q - cnt_t'(1)));

  // Reads are only issued in the states that fetch a point; the read data
  // then holds through the squaring cycles.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      S_LD0: begin
        rd_en = 1'b1;
      end
      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = i_q;
      end
      S_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = cand_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // The single squaring unit works on x in state S_SQX and on y in the next, S_SQY.
  assign sq_a = (state_q == S_SQX) ? x_rd_q : y_rd_q;
  assign sq_b = (state_q == S_SQX) ? px_q : py_q;

  mcr_sq_unit u_sq (
    .a_i  (sq_a),
    .b_i  (sq_b),
    .sq_o (sq_res)
  );

  // Distance to the newest tree node, and the candidate's improved best
  // distance. On the first step the stored best distance is not yet valid.
  assign dist_new = dist_t'(sqx_q) + dist_t'(sqy_q);
  assign best_new = (first_q || (dist_new < best_rd_q)) ? dist_new : best_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && store_ok) begin
      x_mem[cnt_q[IdxW-1:0]] <= in_i.data.x_coord;
    end
    if (rd_en) begin
      x_rd_q <= x_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && store_ok) begin
      y_mem[cnt_q[IdxW-1:0]] <= in_i.data.y_coord;
    end
    if (rd_en) begin
      y_rd_q <= y_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      best_mem[i_q] <= best_new;
    end
    if (rd_en) begin
      best_rd_q <= best_mem[rd_addr];
    end
  end

  // Sequencer. Each tree step scans every node not yet in the tree, relaxes
  // its best distance against the newest node and keeps the lowest-index
  // minimum as the next node to join. A step that finds no node ends the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      in_tree_q   <= '0;
      i_q         <= '0;
      cand_q      <= '0;
      cand_best_q <= '0;
      found_q     <= 1'b0;
      first_q     <= 1'b0;
      run_max_q   <= '0;
      px_q        <= '0;
      py_q        <= '0;
      sqx_q       <= '0;
      sqy_q       <= '0;
      out_o.valid <= 1'b0;
      out_o.data  <= '0;
    end else begin
      // A transfer out frees the result register, unless a new result is
      // loaded into it in the same cycle.
      if (out_o.valid && out_o.ready && (state_q != S_OUT)) begin
        out_o.valid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cnt_q <= cnt_next;
            if (!store_ok) begin
              ovf_q <= 1'b1;
            end
            if (in_i.data.last_point) begin
              n_q     <= cnt_next;
              first_q <= 1'b1;
              if (cnt_next <= cnt_t'(1)) begin
                state_q <= S_OUT;
              end else begin
                state_q <= S_LD0;
              end
            end
          end
        end
        S_LD0: begin
          state_q <= S_LDP;
        end
        S_LDP: begin
          px_q    <= x_rd_q;
          py_q    <= y_rd_q;
          i_q     <= idx_t'(1);
          found_q <= 1'b0;
          state_q <= S_RD;
        end
        S_RD: begin
          if (in_tree_q[i_q]) begin
            if (last_idx) begin
              state_q <= S_NEXT;
            end else begin
              i_q <= i_q + idx_t'(1);
            end
          end else begin
            state_q <= S_SQX;
          end
        end
        S_SQX: begin
          sqx_q   <= sq_res;
          state_q <= S_SQY;
        end
        S_SQY: begin
          sqy_q   <= sq_res;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (!found_q || (best_new < cand_best_q)) begin
            cand_q      <= i_q;
            cand_best_q <= best_new;
            found_q     <= 1'b1;
          end
          if (last_idx) begin
            state_q <= S_NEXT;
          end else begin
            i_q     <= i_q + idx_t'(1);
            state_q <= S_RD;
          end
        end
        S_NEXT: begin
          if (found_q) begin
            in_tree_q[cand_q] <= 1'b1;
            first_q           <= 1'b0;
            if (cand_best_q > run_max_q) begin
              run_max_q <= cand_best_q;
            end
            state_q <= S_LDP;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_o.valid              <= 1'b1;
            out_o.data.range_squared <= run_max_q;
            out_o.data.point_count   <= n_q;
            out_o.data.overflow_flag <= ovf_q;
            cnt_q                    <= '0;
            ovf_q                    <= 1'b0;
            run_max_q                <= '0;
            in_tree_q                <= '0;
            state_q                  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/range_check_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the minimum connecting range block: tracks the point set and
// predicts each range result. Depends on mcr_pkg for sizes and payload structs.
package range_check_pkg;
  import mcr_pkg::*;

  class range_scoreboard;
    coord_t      x_pts[MaxNodes];
    coord_t      y_pts[MaxNodes];
    int unsigned held;
    bit          spilled;
    out_item_t   expected_ranges[$];
    int unsigned failures;

    function new();
      held     = 0;
      spilled  = 0;
      failures = 0;
    endfunction

    function longint unsigned span_sq(int unsigned a, int unsigned b);
      longint unsigned dx;
      longint unsigned dy;
      dx = (x_pts[a] > x_pts[b]) ? x_pts[a] - x_pts[b] : x_pts[b] - x_pts[a];
      dy = (y_pts[a] > y_pts[b]) ? y_pts[a] - y_pts[b] : y_pts[b] - y_pts[a];
      return dx * dx + dy * dy;
    endfunction

    // Prim from point 0; the largest edge taken is the bottleneck of the set.
    function longint unsigned widest_tree_edge();
      longint unsigned reach[MaxNodes];
      bit              joined[MaxNodes];
      longint unsigned widest;
      longint unsigned best;
      longint unsigned d;
      int unsigned     pick;
      bit              found;
      widest = 0;
      if (held <= 1) return 0;
      for (int unsigned i = 1; i < held; i++) begin
        joined[i] = 0;
        reach[i]  = span_sq(0, i);
      end
      for (int unsigned step = 1; step < held; step++) begin
        found = 0;
        best  = 0;
        pick  = 0;
        for (int unsigned i = 1; i < held; i++) begin
          if (!joined[i] && (!found || reach[i] < best)) begin
            best  = reach[i];
            pick  = i;
            found = 1;
          end
        end
        if (!found) break;
        joined[pick] = 1;
        if (best > widest) widest = best;
        for (int unsigned i = 1; i < held; i++) begin
          if (!joined[i]) begin
            d = span_sq(pick, i);
            if (d < reach[i]) reach[i] = d;
          end
        end
      end
      return widest;
    endfunction

    function void note_point(in_item_t it);
      out_item_t want;
      if (held < MaxNodes) begin
        x_pts[held] = it.x_coord;
        y_pts[held] = it.y_coord;
        held++;
      end else begin
        spilled = 1;
      end
      if (it.last_point) begin
        want.range_squared = dist_t'(widest_tree_edge());
        want.point_count   = cnt_t'(held);
        want.overflow_flag = spilled;
        expected_ranges = {expected_ranges, want};
        held    = 0;
        spilled = 0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_ranges.size() == 0) begin
        $error("unexpected result: range_squared %0d point_count %0d",
               got.range_squared, got.point_count);
        failures++;
        return;
      end
      want = expected_ranges.pop_front();
      if (got.range_squared !== want.range_squared) begin
        $error("range_squared: expected %0d, actual %0d", want.range_squared,
               got.range_squared);
        failures++;
      end
      if (got.point_count !== want.point_count) begin
        $error("point_count: expected %0d, actual %0d", want.point_count,
               got.point_count);
        failures++;
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        $error("overflow_flag: expected %0d, actual %0d", want.overflow_flag,
               got.overflow_flag);
        failures++;
      end
    endfunction

    function int unsigned waiting();
      return expected_ranges.size();
    endfunction
  endclass

endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top-level testbench for min_connecting_range_top: drives point sets, checks
// range results. Depends on mcr_pkg, the stream interfaces and range_check_pkg.
module testbench;
  import mcr_pkg::*;
  import range_check_pkg::*;

  // Even a stimulus made only of full 64-point sets with long gaps and heavy
  // output stalls stays well under this limit.
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned ItemTarget  = 1700;

  // Ways to lay out the points of a random set.
  typedef enum int unsigned {
    LAY_SPREAD,
    LAY_CLUSTER,
    LAY_CORNERS,
    LAY_NEAR_DUP
  } layout_e;

  // Moods of the result receiver: always ready, coin flip, or mostly stalled.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_CHOKE
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mcr_in_if  in_if ();
  mcr_out_if out_if ();

  min_connecting_range_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  range_scoreboard sb = new();

  int unsigned sent       = 0;
  int unsigned burst_left = 0;
  int unsigned cycles     = 0;
  int unsigned mode_left  = 0;
  rx_mode_e    rx_mode    = RX_STEADY;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. A hang in the tree search or a lost result ends up here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side. Every accepted transfer is checked against the oldest
  // prediction, and ready follows its own pattern: the mode is picked anew at
  // random when its countdown runs out, so stalls land on all phases of a run,
  // with stretches of steady readiness in between.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 2));
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY: out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        default:   out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Offers one point and holds it until the block takes it. The block drops
  // ready while a tree is being grown, so the wait after a last point covers
  // the whole computation. The sender works in bursts: when one ends, valid
  // goes low for a random gap. Within a burst valid simply stays high, so it
  // is never lowered and raised in the same step.
  task automatic push_point(input coord_t x, input coord_t y, input logic last);
    in_item_t it;
    it.x_coord    = x;
    it.y_coord    = y;
    it.last_point = last;
    in_if.data  <= it;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_point(it);
    sent++;
    if (burst_left <= 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  function automatic coord_t pick_coord(layout_e lay, coord_t anchor);
    case (lay)
      LAY_SPREAD:  return coord_t'($urandom_range(0, 65535));
      LAY_CLUSTER: return anchor + coord_t'($urandom_range(0, 255));
      LAY_CORNERS: return $urandom_range(0, 1) ? '1 : '0;
      default:     return anchor ^ coord_t'($urandom_range(0, 3));
    endcase
  endfunction

  // One set of n points, the last one marked. Each point of a set is, with one
  // chance in ten, scattered at random so that clustered sets still carry long edges.
  task automatic send_set(input int unsigned n, input layout_e lay);
    coord_t ax;
    coord_t ay;
    ax = coord_t'($urandom_range(0, 65535));
    ay = coord_t'($urandom_range(0, 65535));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_point(pick_coord(LAY_SPREAD, ax), pick_coord(LAY_SPREAD, ay), i == n - 1);
      end else begin
        push_point(pick_coord(lay, ax), pick_coord(lay, ay), i == n - 1);
      end
    end
  endtask

  function automatic int unsigned pick_set_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 24);
    if (r < 96) return $urandom_range(25, 63);
    return $urandom_range(MaxNodes, MaxNodes + 16);
  endfunction

  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    burst_left = $urandom_range(1, 40);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets. A lone point gives a zero range, at either corner.
    push_point('1, '0, 1'b1);
    push_point('0, '1, 1'b1);
    // Two points at opposite corners give the largest range there is.
    push_point('0, '0, 1'b0);
    push_point('1, '1, 1'b1);
    push_point('1, '0, 1'b0);
    push_point('0, '1, 1'b1);
    // Two identical points are connected at range zero.
    push_point(16'h1234, 16'hABCD, 1'b0);
    push_point(16'h1234, 16'hABCD, 1'b1);
    // A square: every tree edge ties with others of the same length.
    push_point(16'd0, 16'd0, 1'b0);
    push_point(16'd16, 16'd0, 1'b0);
    push_point(16'd0, 16'd16, 1'b0);
    push_point(16'd16, 16'd16, 1'b1);
    // A line with uneven gaps: the bottleneck is the middle gap, not the first or the last.
    push_point(16'd0, 16'd0, 1'b0);
    push_point(16'd100, 16'd0, 1'b0);
    push_point(16'd1000, 16'd0, 1'b0);
    push_point(16'd1010, 16'd7, 1'b1);

    // A full set, a set whose last point finds the store full, and a set
    // with several dropped points.
    send_set(MaxNodes, LAY_SPREAD);
    send_set(MaxNodes + 1, LAY_CLUSTER);
    send_set(MaxNodes + 7, LAY_NEAR_DUP);

    // Random sets, mostly small since a run scans every candidate on each
    // tree step.
    while (sent < ItemTarget) begin
      send_set(pick_set_size(), layout_e'($urandom_range(0, 3)));
    end

    in_if.valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
